/* sv/ies_pkg.sv */
// Shared types and constants for the interrupt entry sequencer.
// Holds command, acknowledge and result codes, the queued job record and the result beat.
// No dependencies; every other file refers to it by scoped names.
package ies_pkg;

	// Default depth of the job queue between front and back
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// Status register layout and entry constants
	localparam logic [15:0] SR_KEEP   = 16'hF8FF;
	localparam logic [15:0] S_BIT     = 16'h2000;
	localparam logic [15:0] T_BIT     = 16'h8000;
	localparam logic [7:0]  AUTO_BASE = 8'd24;
	localparam logic [2:0]  TOP_LEVEL = 3'd7;
	localparam logic [31:0] PC_PUSH   = 32'd4;
	localparam logic [31:0] FRAME_LEN = 32'd6;

	// Input commands; the fourth code means nothing
	typedef enum logic [1:0] {
		CMD_REQUEST     = 2'd0,
		CMD_SERVICE     = 2'd1,
		CMD_VECTOR_DATA = 2'd2
	} cmd_e_t;

	// Device acknowledge answers; the fourth code acts as spurious
	typedef enum logic [1:0] {
		ACK_VECTOR   = 2'd0,
		ACK_AUTO     = 2'd1,
		ACK_SPURIOUS = 2'd2
	} ack_e_t;

	// Result kinds
	typedef enum logic [2:0] {
		KIND_ACCEPTED    = 3'd0,
		KIND_REFUSED     = 3'd1,
		KIND_NOTHING     = 3'd2,
		KIND_STACK_WRITE = 3'd3,
		KIND_VECTOR_READ = 3'd4,
		KIND_NEW_PC      = 3'd5
	} kind_e_t;

	// One input item, unpacked from the slave beat
	typedef struct packed {
		logic [1:0]  command;
		logic [3:0]  request_level;
		logic [15:0] current_sr;
		logic [31:0] current_ssp;
		logic [31:0] current_pc;
		logic [1:0]  ack_kind;
		logic [7:0]  ack_vector;
		logic [31:0] read_data;
	} in_item_t;

	// Classified job handed from front to back; kind is the first result's kind,
	// a stack write kind means a full three-beat entry
	typedef struct packed {
		kind_e_t     kind;
		logic [2:0]  level;
		logic [15:0] old_sr;
		logic [15:0] entry_sr;
		logic [31:0] pc_slot;
		logic [31:0] sr_slot;
		logic [31:0] data;
		logic [31:0] vector_addr;
	} job_t;

	// One result beat
	typedef struct packed {
		kind_e_t     kind;
		logic [31:0] bus_address;
		logic [31:0] bus_data;
		logic        long_access;
		logic [2:0]  ack_level;
		logic [15:0] new_sr;
		logic [31:0] new_ssp;
		logic [31:0] new_pc;
		logic        wake_from_stop;
		logic        last;
	} beat_t;

endpackage

/* sv/ies_front.sv */
// Front end: accepts items, tracks pending level and outstanding vector read,
// and turns each item into one job for the queue. Depends on ies_pkg.
module ies_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ies_pkg::in_item_t in_item,
	input  logic             queue_full,
	output logic             push,
	output ies_pkg::job_t    push_job
);

	logic [2:0] pending_level_q;
	logic       awaiting_vector_q;
	logic [2:0] level_clamped;
	logic       take_request;
	logic [7:0] vector_num;
	logic       do_entry;
	logic       do_newpc;

	assign in_ready = !queue_full;
	assign push     = in_valid && !queue_full;

	// Clamp the request level to 1..7 and check it against the mask
	always_comb begin
		if (in_item.request_level > 4'(ies_pkg::TOP_LEVEL)) begin
			level_clamped = ies_pkg::TOP_LEVEL;
		end else if (in_item.request_level == 4'd0) begin
			level_clamped = 3'd1;
		end else begin
			level_clamped = in_item.request_level[2:0];
		end
		take_request = (level_clamped > in_item.current_sr[10:8]) ||
			(level_clamped == ies_pkg::TOP_LEVEL);
	end

	// Pick the vector number from the acknowledge answer
	always_comb begin
		case (ies_pkg::ack_e_t'(in_item.ack_kind))
			ies_pkg::ACK_VECTOR: vector_num = in_item.ack_vector;
			ies_pkg::ACK_AUTO:   vector_num = ies_pkg::AUTO_BASE + {5'd0, pending_level_q};
			default:             vector_num = ies_pkg::AUTO_BASE;
		endcase
	end

	// Classify the item into a job
	always_comb begin
		do_entry = 1'b0;
		do_newpc = 1'b0;
		push_job             = '0;
		push_job.kind        = ies_pkg::KIND_NOTHING;
		push_job.level       = pending_level_q;
		push_job.old_sr      = in_item.current_sr;
		push_job.entry_sr    = ((in_item.current_sr & ies_pkg::SR_KEEP) |
			{5'd0, pending_level_q, 8'd0} | ies_pkg::S_BIT) & ~ies_pkg::T_BIT;
		push_job.pc_slot     = in_item.current_ssp - ies_pkg::PC_PUSH;
		push_job.sr_slot     = in_item.current_ssp - ies_pkg::FRAME_LEN;
		push_job.vector_addr = {22'd0, vector_num, 2'b00};
		unique case (ies_pkg::cmd_e_t'(in_item.command))
			ies_pkg::CMD_REQUEST: begin
				push_job.kind = take_request ? ies_pkg::KIND_ACCEPTED : ies_pkg::KIND_REFUSED;
			end
			ies_pkg::CMD_SERVICE: begin
				if (pending_level_q != 3'd0) begin
					do_entry      = 1'b1;
					push_job.kind = ies_pkg::KIND_STACK_WRITE;
					push_job.data = in_item.current_pc;
				end
			end
			ies_pkg::CMD_VECTOR_DATA: begin
				if (awaiting_vector_q) begin
					do_newpc      = 1'b1;
					push_job.kind = ies_pkg::KIND_NEW_PC;
					push_job.data = in_item.read_data;
				end
			end
			default: push_job.kind = ies_pkg::KIND_NOTHING;
		endcase
	end

	// Update pending level and outstanding read on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_level_q   <= 3'd0;
			awaiting_vector_q <= 1'b0;
		end else if (push) begin
			if (push_job.kind == ies_pkg::KIND_ACCEPTED) begin
				pending_level_q <= level_clamped;
			end else if (do_entry) begin
				pending_level_q   <= 3'd0;
				awaiting_vector_q <= 1'b1;
			end else if (do_newpc) begin
				awaiting_vector_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/ies_queue.sv */
// Short job queue between front and back ends.
// Register storage with head and tail pointers; depends on ies_pkg for the job type.
module ies_queue #(
	parameter int unsigned DEPTH = ies_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ies_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output ies_pkg::job_t head_job
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	ies_pkg::job_t entries_q [DEPTH];
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign head_job = entries_q[head_q];

	// Write the tail entry
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[tail_q] <= push_job;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/ies_back.sv */
// Back end: expands each queued job into its result beats and holds them
// in the output register. Depends on ies_pkg.
module ies_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  ies_pkg::job_t head_job,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output ies_pkg::beat_t out_beat
);

	logic [1:0]     beat_q;
	logic           out_valid_q;
	ies_pkg::beat_t out_q;
	ies_pkg::beat_t next_beat;
	logic           load;

	assign load      = !empty && (!out_valid_q || out_ready);
	assign pop       = load && next_beat.last;
	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

	// Build the beat for the head job at the current step
	always_comb begin
		next_beat      = '0;
		next_beat.kind = head_job.kind;
		next_beat.last = 1'b1;
		case (head_job.kind)
			ies_pkg::KIND_REFUSED: next_beat.ack_level = 3'd1;
			ies_pkg::KIND_NEW_PC:  next_beat.new_pc    = head_job.data;
			ies_pkg::KIND_STACK_WRITE: begin
				next_beat.new_sr         = head_job.entry_sr;
				next_beat.new_ssp        = head_job.sr_slot;
				next_beat.wake_from_stop = 1'b1;
				if (beat_q == 2'd0) begin
					next_beat.bus_address = head_job.pc_slot;
					next_beat.bus_data    = head_job.data;
					next_beat.long_access = 1'b1;
					next_beat.last        = 1'b0;
				end else if (beat_q == 2'd1) begin
					next_beat.bus_address = head_job.sr_slot;
					next_beat.bus_data    = {16'd0, head_job.old_sr};
					next_beat.last        = 1'b0;
				end else begin
					next_beat.kind        = ies_pkg::KIND_VECTOR_READ;
					next_beat.bus_address = head_job.vector_addr;
					next_beat.long_access = 1'b1;
					next_beat.ack_level   = head_job.level;
				end
			end
			default: next_beat.kind = head_job.kind;
		endcase
	end

	// Step through the beats of an entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				beat_q <= next_beat.last ? 2'd0 : beat_q + 2'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= next_beat;
		end
	end

endmodule

/* sv/cpu_interrupt_entry_sequencer_top.sv */
// Interrupt acceptance and exception entry sequencer, whose requests and services
// are classified at the input, queued, and expanded into bus and status beats at the output.
// A slave beat is taken in any cycle the job queue has room; jobs are registered in the
// queue and results in the output register. Requests, refusals, empty services and
// vector data give one result beat each; an interrupt entry gives three (PC push, SR
// push, vector read), one per cycle from the single output register while m_tready is
// high, and other items one per cycle likewise. Pending level and vector-read tracking
// live in the front end, so the queue (QUEUE_DEPTH jobs) lets input and output stall apart.
module cpu_interrupt_entry_sequencer_top #(
	parameter int unsigned QUEUE_DEPTH = ies_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// request_level[3:0], current_sr[19:4], current_ssp[51:20], current_pc[83:52],
	// ack_kind[85:84], ack_vector[93:86], read_data[125:94], zero fill
	input  logic [127:0] s_tdata,
	// command[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// bus_address[31:0], bus_data[63:32], long_access[64], ack_level[67:65],
	// new_sr[83:68], new_ssp[115:84], new_pc[147:116], wake_from_stop[148], zero fill
	output logic [151:0] m_tdata,
	// kind[2:0]
	output logic [2:0]   m_tuser,
	output logic         m_tlast
);

	ies_pkg::in_item_t in_item;
	ies_pkg::job_t     push_job;
	ies_pkg::job_t     head_job;
	ies_pkg::beat_t    out_beat;
	logic              push;
	logic              pop;
	logic              full;
	logic              empty;

	// Unpack the slave beat
	always_comb begin
		in_item.command       = s_tuser;
		in_item.request_level = s_tdata[3:0];
		in_item.current_sr    = s_tdata[19:4];
		in_item.current_ssp   = s_tdata[51:20];
		in_item.current_pc    = s_tdata[83:52];
		in_item.ack_kind      = s_tdata[85:84];
		in_item.ack_vector    = s_tdata[93:86];
		in_item.read_data     = s_tdata[125:94];
	end

	ies_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.queue_full (full),
		.push       (push),
		.push_job   (push_job)
	);

	ies_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head_job (head_job)
	);

	ies_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head_job  (head_job),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_beat  (out_beat)
	);

	// Pack the master beat
	assign m_tuser = out_beat.kind;
	assign m_tlast = out_beat.last;
	assign m_tdata = {3'd0, out_beat.wake_from_stop, out_beat.new_pc, out_beat.new_ssp,
		out_beat.new_sr, out_beat.ack_level, out_beat.long_access, out_beat.bus_data,
		out_beat.bus_address};

endmodule

/* sv/ies_checker.sv */
// Port-level checks for the interrupt entry sequencer, bound to the top level.
// Depends on ies_pkg for result kinds.
module ies_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [151:0] m_tdata,
	input logic [2:0]   m_tuser,
	input logic         m_tlast
);

	// A stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("stalled result beat changed");

	// Stack writes never end an item and always wake the core
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ies_pkg::KIND_STACK_WRITE |-> !m_tlast && m_tdata[148])
		else $error("stack write beat malformed");

	// A vector read ends the entry, is a long access at a level above zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ies_pkg::KIND_VECTOR_READ
		|-> m_tlast && m_tdata[64] && m_tdata[67:65] != 3'd0 && m_tdata[1:0] == 2'b00)
		else $error("vector read beat malformed");

	// A vector read follows a taken word-sized SR push
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser == ies_pkg::KIND_STACK_WRITE && !m_tdata[64]
		|=> m_tvalid && m_tuser == ies_pkg::KIND_VECTOR_READ)
		else $error("SR push not followed by vector read");

endmodule

bind cpu_interrupt_entry_sequencer_top ies_checker u_ies_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
